[hw/rtl/wpsm_pkg.sv]
// shared types and constants for the weight prune / splice mask block
package wpsm_pkg;

  localparam int MAG_W   = 16;
  localparam int SQR_W   = 31;
  localparam int ABS_W   = 36;
  localparam int SQ_W    = 51;
  localparam int CNT_W   = 21;
  localparam int LVL_W   = 15;
  localparam int RATE_W  = 16;
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = 51;
  localparam int DS_W    = 52;
  localparam int REM_W   = 29;
  localparam int ROOT_W  = 26;
  localparam int STEP_W  = 6;

  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(DS_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(DS_W / 2);

  localparam logic [LVL_W-1:0]  LEVEL_MAX  = '1;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd4096;

  localparam logic FUNC_STATS  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;
  localparam logic KIND_STATS  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last_step;
  } ds_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_FIN_CHECK,
    ST_DIV_MEAN,
    ST_MUL_MM,
    ST_MUL_SUB,
    ST_VAR_START,
    ST_DIV_VAR,
    ST_SQRT_START,
    ST_SQRT,
    ST_UPD_MUL,
    ST_UPD_CMP
  } st_t;

endpackage

[hw/rtl/wpsm_if.sv]
// item channels of the weight prune / splice mask block
interface wpsm_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [15:0] weight;
  logic              mask_in;
  logic              last_element;

  modport source (output valid, func, weight, mask_in, last_element, input ready);
  modport sink   (input valid, func, weight, mask_in, last_element, output ready);
endinterface

interface wpsm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        new_mask;
  logic [14:0] mean_out;
  logic [14:0] spread_out;
  logic        empty_set;

  modport source (output valid, result_kind, new_mask, mean_out, spread_out, empty_set,
                  input ready);
  modport sink   (input valid, result_kind, new_mask, mean_out, spread_out, empty_set,
                  output ready);
endinterface

[hw/rtl/wpsm_accum.sv]
// saturating magnitude, square and count accumulators
module wpsm_accum #(
  parameter int unsigned MAX_ELEMENTS = 1048576
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         add_en,
  input  logic                         clear,
  input  logic                         mask,
  input  logic [wpsm_pkg::MAG_W-1:0]   mag,
  input  logic [wpsm_pkg::SQR_W-1:0]   square,
  output logic [wpsm_pkg::ABS_W-1:0]   abs_sum,
  output logic [wpsm_pkg::SQ_W-1:0]    square_sum,
  output logic [wpsm_pkg::CNT_W-1:0]   count
);

  localparam int AW = wpsm_pkg::ABS_W;
  localparam int SW = wpsm_pkg::SQ_W;
  localparam int CW = wpsm_pkg::CNT_W;
  localparam longint unsigned CNT_MAX = (64'd1 << CW) - 64'd1;
  localparam logic [CW-1:0] CNT_CAP =
    (MAX_ELEMENTS < CNT_MAX) ? CW'(MAX_ELEMENTS) : CW'(CNT_MAX);
  localparam logic [AW-1:0] ABS_LIM = '1;
  localparam logic [SW-1:0] SQ_LIM  = '1;

  logic          take;
  logic [AW:0]   abs_wide;
  logic [SW:0]   sq_wide;
  logic [AW-1:0] abs_next;
  logic [SW-1:0] sq_next;

  assign take     = add_en && mask && (mag != '0) && (count < CNT_CAP);
  assign abs_wide = {1'b0, abs_sum} + (AW+1)'(mag);
  assign sq_wide  = {1'b0, square_sum} + (SW+1)'(square);
  assign abs_next = (abs_wide > {1'b0, ABS_LIM}) ? ABS_LIM : abs_wide[AW-1:0];
  assign sq_next  = (sq_wide > {1'b0, SQ_LIM}) ? SQ_LIM : sq_wide[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      abs_sum    <= '0;
      square_sum <= '0;
      count      <= '0;
    end else if (take) begin
      abs_sum    <= abs_next;
      square_sum <= sq_next;
      count      <= count + CW'(1);
    end
  end

endmodule

[hw/rtl/wpsm_divsqrt.sv]
// shared radix-2 restoring divide and square-root unit, one step a cycle
module wpsm_divsqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  wpsm_pkg::ds_ctrl_t          ctrl,
  input  logic [wpsm_pkg::DS_W-1:0]   num_in,
  input  logic [wpsm_pkg::CNT_W-1:0]  den_in,
  output wpsm_pkg::ds_stat_t          stat,
  output logic [wpsm_pkg::DS_W-1:0]   result
);

  localparam int DW = wpsm_pkg::DS_W;
  localparam int RW = wpsm_pkg::REM_W;
  localparam int NW = wpsm_pkg::CNT_W;
  localparam int QW = wpsm_pkg::ROOT_W;
  localparam int SW = wpsm_pkg::STEP_W;

  logic                busy;
  wpsm_pkg::ds_mode_t  mode;
  logic [RW-1:0]       rem;
  logic [DW-1:0]       num;
  logic [DW-1:0]       quo;
  logic [NW-1:0]       den;
  logic [SW-1:0]       steps;

  logic [RW-1:0]       cand;
  logic [RW-1:0]       trial;
  logic [DW-1:0]       num_shift;
  logic [RW:0]         diff;
  logic                ge;

  // one subtractor serves both the divide and the root digit
  always_comb begin
    unique case (mode)
      wpsm_pkg::DS_DIV: begin
        cand      = {rem[RW-2:0], num[DW-1]};
        trial     = RW'(den);
        num_shift = {num[DW-2:0], 1'b0};
      end
      wpsm_pkg::DS_SQRT: begin
        cand      = {rem[RW-3:0], num[DW-1:DW-2]};
        trial     = RW'({quo[QW-1:0], 2'b01});
        num_shift = {num[DW-3:0], 2'b00};
      end
      default: begin
        cand      = '0;
        trial     = '0;
        num_shift = '0;
      end
    endcase
  end

  assign diff = {1'b0, cand} - {1'b0, trial};
  assign ge   = !diff[RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      mode  <= wpsm_pkg::DS_DIV;
    end else if (ctrl.start) begin
      busy  <= 1'b1;
      mode  <= ctrl.mode;
      steps <= (ctrl.mode == wpsm_pkg::DS_SQRT) ? wpsm_pkg::SQRT_STEPS : wpsm_pkg::DIV_STEPS;
    end else if (busy) begin
      steps <= steps - SW'(1);
      if (steps == SW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= '0;
      num <= num_in;
      den <= den_in;
    end else if (busy) begin
      rem <= ge ? diff[RW-1:0] : cand;
      quo <= {quo[DW-2:0], ge};
      num <= num_shift;
    end
  end

  assign stat.busy      = busy;
  assign stat.last_step = busy && (steps == SW'(1));
  assign result         = quo;

  property p_start_idle;
    @(posedge clk) disable iff (rst) ctrl.start |-> !busy;
  endproperty
  a_start_idle: assert property (p_start_idle)
    else $error("divsqrt started while busy");

  property p_last_then_idle;
    @(posedge clk) disable iff (rst) stat.last_step |=> !busy;
  endproperty
  a_last_then_idle: assert property (p_last_then_idle)
    else $error("divsqrt did not finish after last step");

  property p_start_busy;
    @(posedge clk) disable iff (rst) ctrl.start |=> busy;
  endproperty
  a_start_busy: assert property (p_start_busy)
    else $error("divsqrt did not go busy after start");

endmodule

[hw/rtl/weight_prune_splice_mask_top.sv]
// top level of the weight prune / splice mask block
//
// in_ch carries one weight item: func, weight (signed q3.12), mask_in and
// last_element. out_ch carries at most one result item per input item.
// cfg_wr_en / cfg_wr_data write prune_rate (unsigned q4.12, reset 1.0);
// write it only while the block is idle.
//
// a statistics item (func 0) goes through accept, square, accumulate.
// with last_element set it then finalizes: mean = abs_sum / count on the
// shared restoring unit, count*mean^2 on the shared multiplier, the
// variance divide and a 26-step square root, after which a statistics
// report is loaded; an empty set (count 0) loads an empty report instead.
// an update item (func 1) goes through accept, threshold multiply,
// compare; the mask result leaves through the output register.
// in_ready is high only in the idle state, so a new item is taken only
// once the last one is through; the shared units serialize these steps.
//
// the output register holds a finished result while the receiver stalls;
// the block goes on accepting items and only waits if a second result is
// ready before the first is taken.
// reset clears the accumulators, the stored levels, the output valid flag and
// sets prune_rate back to 4096.
module weight_prune_splice_mask_top #(
  parameter int unsigned MAX_ELEMENTS = 1048576
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  wpsm_in_if.sink           in_ch,
  wpsm_out_if.source        out_ch
);

  localparam int MW = wpsm_pkg::MAG_W;
  localparam int LW = wpsm_pkg::LVL_W;
  localparam int AW = wpsm_pkg::MUL_A_W;
  localparam int BW = wpsm_pkg::MUL_B_W;
  localparam int PW = wpsm_pkg::MUL_P_W;
  localparam int DW = wpsm_pkg::DS_W;
  localparam int QW = wpsm_pkg::ROOT_W;
  localparam int TW = 36;

  // control state
  wpsm_pkg::st_t state;
  wpsm_pkg::st_t state_next;
  logic          out_valid;

  // configuration and stored levels
  logic [wpsm_pkg::RATE_W-1:0] prune_rate;
  logic [LW-1:0]               mean_level;
  logic [LW-1:0]               deviation_level;

  // held item and working registers
  logic          func_r;
  logic [MW-1:0] mag_r;
  logic          mask_r;
  logic          last_r;
  logic [PW-1:0] prod;
  logic [LW-1:0] mean_tmp;

  // output payload register
  logic          res_kind;
  logic          res_mask;
  logic [LW-1:0] res_mean;
  logic [LW-1:0] res_spread;
  logic          res_empty;

  // accumulators
  logic [wpsm_pkg::ABS_W-1:0] abs_sum;
  logic [wpsm_pkg::SQ_W-1:0]  square_sum;
  logic [wpsm_pkg::CNT_W-1:0] count;

  // shared unit
  wpsm_pkg::ds_ctrl_t ds_ctrl;
  wpsm_pkg::ds_stat_t ds_stat;
  logic [DW-1:0]      ds_num;
  logic [DW-1:0]      ds_result;

  // fsm outputs
  logic in_accept;
  logic out_free;
  logic acc_en;
  logic acc_clear;
  logic mul_en;
  logic mean_load;
  logic res_load;
  logic lvl_load;

  // combinational datapath
  logic [MW-1:0]  in_mag;
  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  mul_p;
  logic [LW-1:0]  q_mean;
  logic [LW-1:0]  q_root;
  logic [PW-1:0]  var_num;
  logic [LW:0]    lvl_sum;
  logic [TW-1:0]  thr;
  logic [TW-1:0]  thr_low;
  logic [TW-1:0]  thr_high;
  logic [TW-1:0]  lhs;
  logic           upd_mask;
  logic           res_kind_next;
  logic           res_mask_next;
  logic [LW-1:0]  res_mean_next;
  logic [LW-1:0]  res_spread_next;
  logic           res_empty_next;

  // magnitude of the two's complement weight; -32768 maps to 32768
  assign in_mag    = in_ch.weight[MW-1] ? MW'(~in_ch.weight + 16'sd1) : MW'(in_ch.weight);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;

  wpsm_accum #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .add_en     (acc_en),
    .clear      (acc_clear),
    .mask       (mask_r),
    .mag        (mag_r),
    .square     (prod[wpsm_pkg::SQR_W-1:0]),
    .abs_sum    (abs_sum),
    .square_sum (square_sum),
    .count      (count)
  );

  wpsm_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ds_ctrl),
    .num_in (ds_num),
    .den_in (count),
    .stat   (ds_stat),
    .result (ds_result)
  );

  // single shared multiplier, operands picked by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      wpsm_pkg::ST_SQUARE: begin
        mul_a = AW'(mag_r);
        mul_b = BW'(mag_r);
      end
      wpsm_pkg::ST_MUL_MM: begin
        mul_a = AW'(mean_tmp);
        mul_b = BW'(mean_tmp);
      end
      wpsm_pkg::ST_MUL_SUB: begin
        mul_a = prod[AW-1:0];
        mul_b = count;
      end
      wpsm_pkg::ST_UPD_MUL: begin
        mul_a = AW'(lvl_sum);
        mul_b = BW'(prune_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PW'(mul_a * mul_b);
  assign lvl_sum = {1'b0, mean_level} + {1'b0, deviation_level};

  // quotient and root saturate to the q3.12 level range
  assign q_mean  = (|ds_result[DW-1:LW]) ? wpsm_pkg::LEVEL_MAX : ds_result[LW-1:0];
  assign q_root  = (|ds_result[QW-1:LW]) ? wpsm_pkg::LEVEL_MAX : ds_result[LW-1:0];
  assign var_num = (square_sum > prod) ? (square_sum - prod) : '0;

  // shared unit operand
  always_comb begin
    case (state)
      wpsm_pkg::ST_FIN_CHECK:  ds_num = DW'(abs_sum);
      wpsm_pkg::ST_VAR_START:  ds_num = DW'(var_num);
      default:                 ds_num = ds_result;
    endcase
  end

  // threshold compare: 10*|w|*4096 against 9*t and 11*t
  assign thr      = TW'(prod[31:0]);
  assign thr_low  = (thr << 3) + thr;
  assign thr_high = (thr << 3) + (thr << 1) + thr;
  assign lhs      = (TW'(mag_r) << 15) + (TW'(mag_r) << 13);

  always_comb begin
    upd_mask = mask_r;
    if (mask_r && (lhs <= thr_low)) begin
      upd_mask = 1'b0;
    end else if (!mask_r && (lhs > thr_high)) begin
      upd_mask = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wpsm_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = (in_ch.func == wpsm_pkg::FUNC_UPDATE) ? wpsm_pkg::ST_UPD_MUL
                                                             : wpsm_pkg::ST_SQUARE;
        end
      end
      wpsm_pkg::ST_SQUARE:     state_next = wpsm_pkg::ST_ACCUM;
      wpsm_pkg::ST_ACCUM:      state_next = last_r ? wpsm_pkg::ST_FIN_CHECK : wpsm_pkg::ST_IDLE;
      wpsm_pkg::ST_FIN_CHECK: begin
        if (count != '0) begin
          state_next = wpsm_pkg::ST_DIV_MEAN;
        end else if (out_free) begin
          state_next = wpsm_pkg::ST_IDLE;
        end
      end
      wpsm_pkg::ST_DIV_MEAN: begin
        if (!ds_stat.busy) begin
          state_next = wpsm_pkg::ST_MUL_MM;
        end
      end
      wpsm_pkg::ST_MUL_MM:     state_next = wpsm_pkg::ST_MUL_SUB;
      wpsm_pkg::ST_MUL_SUB:    state_next = wpsm_pkg::ST_VAR_START;
      wpsm_pkg::ST_VAR_START:  state_next = wpsm_pkg::ST_DIV_VAR;
      wpsm_pkg::ST_DIV_VAR: begin
        if (!ds_stat.busy) begin
          state_next = wpsm_pkg::ST_SQRT_START;
        end
      end
      wpsm_pkg::ST_SQRT_START: state_next = wpsm_pkg::ST_SQRT;
      wpsm_pkg::ST_SQRT: begin
        if (!ds_stat.busy && out_free) begin
          state_next = wpsm_pkg::ST_IDLE;
        end
      end
      wpsm_pkg::ST_UPD_MUL:    state_next = wpsm_pkg::ST_UPD_CMP;
      wpsm_pkg::ST_UPD_CMP: begin
        if (out_free) begin
          state_next = wpsm_pkg::ST_IDLE;
        end
      end
      default:                 state_next = wpsm_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs and result payload
  always_comb begin
    in_ch.ready     = 1'b0;
    acc_en          = 1'b0;
    acc_clear       = 1'b0;
    mul_en          = 1'b0;
    mean_load       = 1'b0;
    res_load        = 1'b0;
    lvl_load        = 1'b0;
    ds_ctrl.start   = 1'b0;
    ds_ctrl.mode    = wpsm_pkg::DS_DIV;
    res_kind_next   = wpsm_pkg::KIND_STATS;
    res_mask_next   = 1'b0;
    res_mean_next   = '0;
    res_spread_next = '0;
    res_empty_next  = 1'b0;
    unique case (state)
      wpsm_pkg::ST_IDLE:       in_ch.ready = 1'b1;
      wpsm_pkg::ST_SQUARE:     mul_en = 1'b1;
      wpsm_pkg::ST_ACCUM:      acc_en = 1'b1;
      wpsm_pkg::ST_FIN_CHECK: begin
        if (count != '0) begin
          ds_ctrl.start = 1'b1;
        end else if (out_free) begin
          // empty set: zero levels and the flag
          res_load       = 1'b1;
          lvl_load       = 1'b1;
          acc_clear      = 1'b1;
          res_empty_next = 1'b1;
        end
      end
      wpsm_pkg::ST_DIV_MEAN:   mean_load = !ds_stat.busy;
      wpsm_pkg::ST_MUL_MM:     mul_en = 1'b1;
      wpsm_pkg::ST_MUL_SUB:    mul_en = 1'b1;
      wpsm_pkg::ST_VAR_START:  ds_ctrl.start = 1'b1;
      wpsm_pkg::ST_DIV_VAR:    ds_ctrl.mode = wpsm_pkg::DS_DIV;
      wpsm_pkg::ST_SQRT_START: begin
        ds_ctrl.start = 1'b1;
        ds_ctrl.mode  = wpsm_pkg::DS_SQRT;
      end
      wpsm_pkg::ST_SQRT: begin
        if (!ds_stat.busy && out_free) begin
          res_load        = 1'b1;
          lvl_load        = 1'b1;
          acc_clear       = 1'b1;
          res_mean_next   = mean_tmp;
          res_spread_next = q_root;
        end
      end
      wpsm_pkg::ST_UPD_MUL:    mul_en = 1'b1;
      wpsm_pkg::ST_UPD_CMP: begin
        if (out_free) begin
          res_load      = 1'b1;
          res_kind_next = wpsm_pkg::KIND_UPDATE;
          res_mask_next = upd_mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= wpsm_pkg::ST_IDLE;
      out_valid       <= 1'b0;
      prune_rate      <= wpsm_pkg::RATE_RESET;
      mean_level      <= '0;
      deviation_level <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        prune_rate <= cfg_wr_data;
      end
      if (lvl_load) begin
        mean_level      <= res_mean_next;
        deviation_level <= res_spread_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_ch.func;
      mag_r  <= in_mag;
      mask_r <= in_ch.mask_in;
      last_r <= in_ch.last_element;
    end
    if (mul_en) begin
      prod <= mul_p;
    end
    if (mean_load) begin
      mean_tmp <= q_mean;
    end
    if (res_load) begin
      res_kind   <= res_kind_next;
      res_mask   <= res_mask_next;
      res_mean   <= res_mean_next;
      res_spread <= res_spread_next;
      res_empty  <= res_empty_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = res_kind;
  assign out_ch.new_mask    = res_mask;
  assign out_ch.mean_out    = res_mean;
  assign out_ch.spread_out  = res_spread;
  assign out_ch.empty_set   = res_empty;

  // the held item's func picks the branch it took
  property p_func_path;
    @(posedge clk) disable iff (rst)
      (state == wpsm_pkg::ST_UPD_MUL) |-> (func_r == wpsm_pkg::FUNC_UPDATE);
  endproperty
  a_func_path: assert property (p_func_path)
    else $error("update path entered for a statistics item");

  property p_clear_count;
    @(posedge clk) disable iff (rst) acc_clear |=> (count == '0);
  endproperty
  a_clear_count: assert property (p_clear_count)
    else $error("accumulators not cleared after finalize");

  property p_empty_levels;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.empty_set) |->
        (out_ch.mean_out == '0 && out_ch.spread_out == '0 &&
         out_ch.result_kind == wpsm_pkg::KIND_STATS);
  endproperty
  a_empty_levels: assert property (p_empty_levels)
    else $error("empty report with nonzero levels");

  property p_update_payload;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.result_kind == wpsm_pkg::KIND_UPDATE) |->
        (!out_ch.empty_set && out_ch.mean_out == '0 && out_ch.spread_out == '0);
  endproperty
  a_update_payload: assert property (p_update_payload)
    else $error("update result carries statistics fields");

  property p_load_when_free;
    @(posedge clk) disable iff (rst)
      (out_valid && !out_ch.ready) |-> !res_load;
  endproperty
  a_load_when_free: assert property (p_load_when_free)
    else $error("result overwritten while receiver stalls");

endmodule

[test/weight_prune_splice_mask_top_tb.sv]
// self-checking testbench for weight_prune_splice_mask_top: directed and random items, scored
module weight_prune_splice_mask_top_tb;

  // small element cap so the saturated-count case is reachable in a short run
  localparam int CAP_ELEMS   = 64;
  localparam int ITEM_TARGET = 1500;
  localparam int QUIET_AFTER = 1300;   // items made after this carry no input gaps
  localparam int CALM_JOBS   = 150;    // receiver stops stalling when this few jobs remain
  localparam int SETTLE      = 8;      // idle cycles before a rate write
  localparam int TAIL        = 40;
  localparam int LIMIT       = 400000;

  // 0.9 and 1.1 as ratios over ten, so the bounds compare exactly
  localparam longint unsigned PRUNE_NUM  = 9;
  localparam longint unsigned SPLICE_NUM = 11;
  localparam longint unsigned RATIO_DEN  = 10;
  localparam longint unsigned ONE_Q12    = 4096;

  localparam longint unsigned ABS_LIM = (64'd1 << wpsm_pkg::ABS_W) - 1;
  localparam longint unsigned SQ_LIM  = (64'd1 << wpsm_pkg::SQ_W) - 1;
  localparam longint unsigned CNT_LIM = (64'd1 << wpsm_pkg::CNT_W) - 1;

  typedef enum logic {
    JOB_WEIGHT,
    JOB_RATE
  } job_kind_t;

  // one entry of the stimulus queue: a weight item or a prune_rate write
  typedef struct {
    job_kind_t   kind;
    logic        fn;
    logic [15:0] w;
    logic        keep;
    logic        fin;
    logic [15:0] rate;
    int          gap;
  } job_t;

  typedef struct packed {
    logic                       kind;
    logic                       new_mask;
    logic [wpsm_pkg::LVL_W-1:0] mean;
    logic [wpsm_pkg::LVL_W-1:0] spread;
    logic                       empty;
  } mask_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // everything the testbench drives, known from time zero
  logic        drv_valid   = 1'b0;
  logic        drv_func    = 1'b0;
  logic [15:0] drv_weight  = '0;
  logic        drv_mask    = 1'b0;
  logic        drv_last    = 1'b0;
  logic        take_ready  = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  wpsm_in_if  in_ch ();
  wpsm_out_if out_ch ();

  assign in_ch.valid        = drv_valid;
  assign in_ch.func         = drv_func;
  assign in_ch.weight       = drv_weight;
  assign in_ch.mask_in      = drv_mask;
  assign in_ch.last_element = drv_last;
  assign out_ch.ready       = take_ready;

  weight_prune_splice_mask_top #(
    .MAX_ELEMENTS(CAP_ELEMS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk = ~clk;

  // shadow state of the block: threshold scale, accumulators and finalized levels
  logic [wpsm_pkg::RATE_W-1:0] prune_rate = wpsm_pkg::RATE_RESET;
  longint unsigned             acc_abs    = 0;
  longint unsigned             acc_sq     = 0;
  longint unsigned             acc_cnt    = 0;
  logic [wpsm_pkg::LVL_W-1:0]  lvl_mean   = '0;
  logic [wpsm_pkg::LVL_W-1:0]  lvl_dev    = '0;

  job_t      weight_jobs[$];
  mask_res_t mask_due[$];
  job_t      job;
  logic      job_held   = 1'b0;
  int        gap_left   = 0;
  int        settle_left = 0;
  int        accepts    = 0;
  int        accepts_seen = 0;
  logic      all_done   = 1'b0;
  logic      calm       = 1'b0;
  int        hold_left  = 0;
  int        items_made = 0;
  int        errors     = 0;
  int        cycle_cnt  = 0;

  function automatic longint unsigned clamp_add(input longint unsigned a, b, lim);
    return (a >= lim || b > lim - a) ? lim : a + b;
  endfunction

  // one item through the shadow state; returns 1 when the item yields a result
  function automatic logic surgery_step(input logic fn, input logic [15:0] w,
                                        input logic keep, input logic fin,
                                        output mask_res_t r);
    longint unsigned mag, m, sub, vq, sd, thr, lhs;
    int b;
    r = '0;
    mag = {48'd0, w};
    if (w[15]) begin
      mag = 65536 - mag;
    end
    if (fn == wpsm_pkg::FUNC_UPDATE) begin
      thr = longint'(prune_rate) * (longint'(lvl_mean) + longint'(lvl_dev));
      lhs = mag * ONE_Q12 * RATIO_DEN;
      r.kind = wpsm_pkg::KIND_UPDATE;
      r.new_mask = keep;
      if (keep && lhs <= PRUNE_NUM * thr) begin
        r.new_mask = 1'b0;
      end else if (!keep && lhs > SPLICE_NUM * thr) begin
        r.new_mask = 1'b1;
      end
      return 1'b1;
    end
    // zero and pruned weights are skipped, and the count stops at the cap
    if (keep && mag != 0 && acc_cnt < CAP_ELEMS && acc_cnt < CNT_LIM) begin
      acc_abs = clamp_add(acc_abs, mag, ABS_LIM);
      acc_sq  = clamp_add(acc_sq, mag * mag, SQ_LIM);
      acc_cnt = acc_cnt + 1;
    end
    if (!fin) begin
      return 1'b0;
    end
    if (acc_cnt == 0) begin
      lvl_mean = '0;
      lvl_dev  = '0;
      r.empty  = 1'b1;
    end else begin
      m = acc_abs / acc_cnt;
      if (m > wpsm_pkg::LEVEL_MAX) begin
        m = wpsm_pkg::LEVEL_MAX;
      end
      sub = acc_cnt * m * m;
      vq = (acc_sq > sub) ? (acc_sq - sub) / acc_cnt : 0;
      // floor square root, one bit at a time from the top
      sd = 0;
      for (b = 26; b >= 0; b--) begin
        if (((sd | (64'd1 << b)) * (sd | (64'd1 << b))) <= vq) begin
          sd = sd | (64'd1 << b);
        end
      end
      if (sd > wpsm_pkg::LEVEL_MAX) begin
        sd = wpsm_pkg::LEVEL_MAX;
      end
      lvl_mean = m[wpsm_pkg::LVL_W-1:0];
      lvl_dev  = sd[wpsm_pkg::LVL_W-1:0];
    end
    r.kind   = wpsm_pkg::KIND_STATS;
    r.mean   = lvl_mean;
    r.spread = lvl_dev;
    acc_abs  = 0;
    acc_sq   = 0;
    acc_cnt  = 0;
    return 1'b1;
  endfunction

  // weights biased toward extremes and small magnitudes so thresholds land in range
  function automatic logic [15:0] pick_weight();
    int unsigned sel;
    logic [15:0] v;
    sel = $urandom_range(9);
    v = 16'($urandom_range(16'hFFFF));
    if (sel == 0) begin
      case ($urandom_range(4))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = 16'h0000;
        3:       v = 16'hFFFF;
        default: v = 16'h0001;
      endcase
    end else if (sel < 5) begin
      v = 16'($urandom_range(4095));
      if ($urandom_range(1)) v = -v;
    end else if (sel < 7) begin
      v = 16'($urandom_range(255));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  task automatic add_item(input logic fn, input logic [15:0] w, input logic keep,
                          input logic fin);
    job_t j;
    j.kind = JOB_WEIGHT;
    j.fn   = fn;
    j.w    = w;
    j.keep = keep;
    j.fin  = fin;
    j.rate = '0;
    j.gap  = (items_made < QUIET_AFTER && $urandom_range(3) == 0) ?
             int'($urandom_range(1, 3)) : 0;
    weight_jobs = {weight_jobs, j};
    items_made++;
  endtask

  task automatic add_rate(input logic [15:0] r);
    job_t j;
    j.kind = JOB_RATE;
    j.fn   = 1'b0;
    j.w    = '0;
    j.keep = 1'b0;
    j.fin  = 1'b0;
    j.rate = r;
    j.gap  = 0;
    weight_jobs = {weight_jobs, j};
  endtask

  task automatic flag_error(input string what, input mask_res_t want, input mask_res_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s at cycle %0d: expected kind %0d mask %0d mean %0d spread %0d empty %0d,",
               what, cycle_cnt, want.kind, want.new_mask, want.mean, want.spread, want.empty);
      $display("  got kind %0d mask %0d mean %0d spread %0d empty %0d",
               got.kind, got.new_mask, got.mean, got.spread, got.empty);
    end
  endtask

  // sender: holds an item until it is taken, then inserts the next job's gap;
  // a rate write waits for every result to arrive plus a settle wait
  always @(negedge clk) begin : feed
    logic nvalid;
    logic nwr;
    if (!rst) begin
      nvalid = drv_valid && (accepts == accepts_seen);
      accepts_seen = accepts;
      nwr = 1'b0;
      if (!nvalid) begin
        if (!job_held && weight_jobs.size() > 0) begin
          job = weight_jobs.pop_front();
          job_held = 1'b1;
          gap_left = job.gap;
          settle_left = SETTLE;
        end
        if (job_held) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (job.kind == JOB_WEIGHT) begin
            drv_func   <= job.fn;
            drv_weight <= job.w;
            drv_mask   <= job.keep;
            drv_last   <= job.fin;
            nvalid = 1'b1;
            job_held = 1'b0;
          end else if (mask_due.size() != 0) begin
            settle_left = SETTLE;
          end else if (settle_left > 0) begin
            settle_left--;
          end else begin
            // block is idle: the shadow rate changes with the register
            cfg_wr_data <= job.rate;
            nwr = 1'b1;
            prune_rate = job.rate;
            job_held = 1'b0;
          end
        end
      end
      drv_valid <= nvalid;
      cfg_wr_en <= nwr;
    end
  end

  // receiver: random stall bursts, always ready near the end
  always @(negedge clk) begin : drain
    if (!rst) begin
      if (calm) begin
        take_ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if ($urandom_range(3) == 0) begin
        hold_left = int'($urandom_range(2));
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  // monitor: scores results first, then predicts for an item taken this edge
  always @(posedge clk) begin : watch
    mask_res_t got;
    mask_res_t want;
    mask_res_t fresh;
    cycle_cnt++;
    if (!rst) begin
      if (out_ch.valid && take_ready) begin
        got = {out_ch.result_kind, out_ch.new_mask, out_ch.mean_out, out_ch.spread_out,
               out_ch.empty_set};
        if (mask_due.size() == 0) begin
          flag_error("unexpected result", '0, got);
        end else begin
          want = mask_due.pop_front();
          if (got !== want) begin
            flag_error("result mismatch", want, got);
          end
        end
      end
      if (drv_valid && in_ch.ready) begin
        accepts++;
        if (surgery_step(drv_func, drv_weight, drv_mask, drv_last, fresh)) begin
          mask_due = {mask_due, fresh};
        end
      end
      calm = weight_jobs.size() < CALM_JOBS;
      all_done = weight_jobs.size() == 0 && !job_held && !drv_valid && mask_due.size() == 0;
    end
  end

  initial begin : stimulus
    int n;
    int k;
    int phase;
    logic [15:0] r;

    // levels still zero, so the threshold is zero
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0000, 1'b1, 1'b0);   // kept zero weight gets pruned
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0001, 1'b0, 1'b0);   // pruned nonzero weight spliced
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0000, 1'b0, 1'b0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h8000, 1'b1, 1'b1);   // last mark ignored on update
    // empty set: only a zero weight seen
    add_item(wpsm_pkg::FUNC_STATS, 16'h0000, 1'b1, 1'b1);
    // pruned element skipped, two full-scale negatives saturate the mean
    add_item(wpsm_pkg::FUNC_STATS, 16'h7FFF, 1'b0, 1'b0);
    add_item(wpsm_pkg::FUNC_STATS, 16'h8000, 1'b1, 1'b0);
    add_item(wpsm_pkg::FUNC_STATS, 16'h8000, 1'b1, 1'b1);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h7FFF, 1'b0, 1'b0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h8000, 1'b1, 1'b0);
    // equal magnitudes give zero spread
    add_item(wpsm_pkg::FUNC_STATS, 16'd100, 1'b1, 1'b0);
    add_item(wpsm_pkg::FUNC_STATS, 16'hFF9C, 1'b1, 1'b1);
    add_item(wpsm_pkg::FUNC_STATS, 16'h0001, 1'b1, 1'b1);    // mean 1, spread 0
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0001, 1'b1, 1'b0);
    // rate 10.0 with mean 1 puts the prune bound at 9 and the splice bound at 11
    add_rate(16'd40960);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'd9, 1'b1, 1'b0);      // on the prune bound: pruned
    add_item(wpsm_pkg::FUNC_UPDATE, 16'd10, 1'b1, 1'b0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'd11, 1'b0, 1'b0);     // on the splice bound: stays out
    add_item(wpsm_pkg::FUNC_UPDATE, 16'd12, 1'b0, 1'b0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'hFFF4, 1'b0, 1'b0);
    add_rate(16'd0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0001, 1'b0, 1'b0);
    add_item(wpsm_pkg::FUNC_UPDATE, 16'h0000, 1'b1, 1'b0);

    // random phases: one rate each, then statistics passes followed by updates
    phase = 0;
    while (items_made < ITEM_TARGET) begin
      case (phase % 5)
        0:       r = 16'($urandom_range(16'hFFFF));
        1:       r = 16'hFFFF;
        2:       r = wpsm_pkg::RATE_RESET;
        3:       r = 16'($urandom_range(1024, 12288));
        default: r = 16'd0;
      endcase
      add_rate(r);
      repeat ($urandom_range(2, 5)) begin
        // mostly short sets, now and then one that runs past the element cap
        n = ($urandom_range(9) == 0) ? int'($urandom_range(CAP_ELEMS - 4, CAP_ELEMS + 16))
                                     : int'($urandom_range(1, 20));
        for (k = 0; k < n; k++) begin
          add_item(wpsm_pkg::FUNC_STATS, pick_weight(), $urandom_range(4) != 0, k == n - 1);
          // stray update in the middle of a pass
          if ($urandom_range(24) == 0) begin
            add_item(wpsm_pkg::FUNC_UPDATE, pick_weight(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
          end
        end
        repeat ($urandom_range(4, 24)) begin
          add_item(wpsm_pkg::FUNC_UPDATE, pick_weight(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        end
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!all_done && cycle_cnt < LIMIT) @(negedge clk);
    if (cycle_cnt >= LIMIT) begin
      $display("FAIL");
    end else begin
      // let any stray result show up before the verdict
      repeat (TAIL) @(negedge clk);
      if (errors == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
